// File: hdl/brf_pkg.sv
package brf_pkg;

  localparam int MEM_BYTES = 65536;
  localparam int MAX_WIDTH = 4096;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int XW        = $clog2(MAX_WIDTH) + 1;
  localparam int BYTE_W    = XW - 3;
  localparam int YW        = 13;
  localparam int FILL_AW   = 24;
  localparam int PIX_W     = 26;
  localparam logic [7:0] LEFT_BIT = 8'h80;
  localparam int BITS_PER_BYTE = 8;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_ROW_STRIDE   = 3'd2,
    REG_IMAGE_BASE   = 3'd3,
    REG_ORIGIN_X     = 3'd4,
    REG_ORIGIN_Y     = 3'd5,
    REG_SCALE_X      = 3'd6,
    REG_SCALE_Y      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [23:0] x_start;
    logic signed [23:0] y_start;
    logic signed [23:0] x_end;
    logic signed [23:0] y_end;
    logic [15:0]        byte_address;
    logic [7:0]         byte_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       done_res;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic signed [23:0] coord;
    logic signed [23:0] origin;
    logic [23:0]        scale;
  } conv_req_t;

  typedef struct packed {
    logic                    valid;
    logic signed [PIX_W-1:0] pix;
  } conv_rsp_t;

endpackage

// File: hdl/brf_scale.sv
module brf_scale (
  input  logic              clk,
  input  logic              rst,
  input  brf_pkg::conv_req_t req,
  output brf_pkg::conv_rsp_t rsp
);
  import brf_pkg::*;

  logic signed [24:0] diff;
  logic [24:0]        mag;
  logic               v1;
  logic               neg1;
  logic [24:0]        mag1;
  logic [23:0]        scale1;
  logic               v2;
  logic               neg2;
  logic [48:0]        prod2;
  logic [PIX_W-1:0]   qz;

  always_comb begin
    diff = 25'(req.coord) - 25'(req.origin);
    mag  = diff[24] ? (25'd0 - diff) : diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= req.valid;
      v2 <= v1;
    end
    neg1   <= diff[24];
    mag1   <= mag;
    scale1 <= req.scale;
    neg2   <= neg1;
    prod2  <= mag1 * scale1;
  end

  // drop the 8+16 fraction bits, truncating toward zero
  always_comb begin
    qz        = PIX_W'(prod2[48:24]);
    rsp.valid = v2;
    rsp.pix   = neg2 ? (PIX_W'(0) - qz) : qz;
  end

endmodule

// File: hdl/bitmap_rect_fill_1bpp_core.sv
// Rectangle fill on a 1 bpp bitmap kept in a single-port byte memory of MEM_BYTES
// entries (contents undefined until written; leftmost pixel in the msb). Opcode 0
// clears and 1 sets the pixels of a rectangle given by two corners in 1/256 mm,
// converted with origin_x/y and the Q8.16 scale_x/y; 2 writes and 3 reads a byte.
// Each item returns exactly one result. A fill first runs four coordinate conversions
// through one shared two-stage multiplier, then clamping and the row address, and
// then walks the touched bytes; each byte within the memory is a read then a write
// on the one memory port. Bytes at or above MEM_BYTES are skipped. Registers are
// written over the APB port; the user must write them only while idle, as the block
// itself does not enforce it.
module bitmap_rect_fill_1bpp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  brf_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output brf_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import brf_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CONV   = 10'b0000000010,
    S_CLAMP  = 10'b0000000100,
    S_ROW0   = 10'b0000001000,
    S_RMW_RD = 10'b0000010000,
    S_RMW_WR = 10'b0000100000,
    S_WRITE  = 10'b0001000000,
    S_RD_REQ = 10'b0010000000,
    S_RD_DAT = 10'b0100000000,
    S_FINISH = 10'b1000000000
  } state_t;

  // configuration registers
  logic [12:0]        image_width;
  logic [12:0]        image_height;
  logic [9:0]         row_stride;
  logic [15:0]        image_base;
  logic signed [23:0] origin_x;
  logic signed [23:0] origin_y;
  logic [23:0]        scale_x;
  logic [23:0]        scale_y;

  state_t             state;
  logic               fill_set;
  logic [15:0]        item_addr;
  logic [7:0]         item_data;
  logic signed [23:0] corner [4];
  logic [2:0]         issue_cnt;
  logic [1:0]         rsp_cnt;
  logic signed [PIX_W-1:0] pix_q [4];
  logic [XW-1:0]      xs;
  logic [XW-1:0]      xe;
  logic [YW-1:0]      ys;
  logic [YW-1:0]      ye;
  logic               empty;
  logic [YW-1:0]      y;
  logic [BYTE_W-1:0]  b;
  logic [FILL_AW-1:0] row_addr;
  logic [7:0]         rd_value;

  logic               cfg_we;
  reg_idx_t           cfg_idx;
  conv_req_t          creq;
  conv_rsp_t          crsp;

  logic [7:0]         mem [MEM_BYTES];
  logic [MEM_AW-1:0]  mem_addr;
  logic               mem_we;
  logic [7:0]         mem_wdata;
  logic [7:0]         mem_rdata;

  logic [XW-1:0]      w_lim;
  logic signed [PIX_W-1:0] w_s, h_s, xs_c, xe_c, ys_c, ye_c;
  logic [XW-1:0]      xe1;
  logic [BYTE_W-1:0]  bfirst, blast;
  logic [7:0]         mask;
  logic [FILL_AW-1:0] fill_addr;
  logic               fill_in_range;
  logic               last_byte, last_row;
  logic [22:0]        row_off;
  logic               item_in_range;
  logic signed [23:0] xa, xb, ya, yb;

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign cfg_we   = psel & penable & pwrite;
  assign cfg_idx  = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd1;
      image_height <= 13'd1;
      row_stride   <= 10'd4;
      image_base   <= 16'd0;
      origin_x     <= 24'sd0;
      origin_y     <= 24'sd0;
      scale_x      <= 24'd65536;
      scale_y      <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[12:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[12:0];
        REG_ROW_STRIDE:   row_stride   <= pwdata[9:0];
        REG_IMAGE_BASE:   image_base   <= pwdata[15:0];
        REG_ORIGIN_X:     origin_x     <= pwdata[23:0];
        REG_ORIGIN_Y:     origin_y     <= pwdata[23:0];
        REG_SCALE_X:      scale_x      <= pwdata[23:0];
        REG_SCALE_Y:      scale_y      <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      REG_ROW_STRIDE:   prdata = 32'(row_stride);
      REG_IMAGE_BASE:   prdata = 32'(image_base);
      REG_ORIGIN_X:     prdata = 32'(unsigned'(origin_x));
      REG_ORIGIN_Y:     prdata = 32'(unsigned'(origin_y));
      REG_SCALE_X:      prdata = 32'(scale_x);
      REG_SCALE_Y:      prdata = 32'(scale_y);
      default:          prdata = 32'd0;
    endcase
  end

  // corners in order per axis
  always_comb begin
    xa = (in_data.x_start > in_data.x_end) ? in_data.x_end : in_data.x_start;
    xb = (in_data.x_start > in_data.x_end) ? in_data.x_start : in_data.x_end;
    ya = (in_data.y_start > in_data.y_end) ? in_data.y_end : in_data.y_start;
    yb = (in_data.y_start > in_data.y_end) ? in_data.y_start : in_data.y_end;
  end

  // conversions in order xs, xe, ys, ye
  always_comb begin
    creq.valid  = (state == S_CONV) && !issue_cnt[2];
    creq.coord  = corner[issue_cnt[1:0]];
    creq.origin = issue_cnt[1] ? origin_y : origin_x;
    creq.scale  = issue_cnt[1] ? scale_y : scale_x;
  end

  brf_scale u_scale (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  // clamping
  always_comb begin
    w_lim = (XW'(image_width) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(image_width);
    w_s   = PIX_W'(w_lim);
    h_s   = PIX_W'(image_height);
    xs_c  = (pix_q[0] < 0) ? PIX_W'(0) : pix_q[0];
    xe_c  = (pix_q[1] > w_s) ? w_s : pix_q[1];
    ys_c  = (pix_q[2] < 0) ? PIX_W'(0) : pix_q[2];
    ye_c  = (pix_q[3] > h_s) ? h_s : pix_q[3];
  end

  // byte walk
  always_comb begin
    xe1    = xe - 1'b1;
    bfirst = xs[XW-1:3];
    blast  = xe1[XW-1:3];
    mask   = 8'hFF;
    if (b == bfirst) mask = mask & (8'hFF >> xs[2:0]);
    if (b == blast)  mask = mask & (8'hFF << (3'd7 - xe1[2:0]));
    fill_addr     = row_addr + FILL_AW'(b);
    fill_in_range = fill_addr < FILL_AW'(MEM_BYTES);
    last_byte     = (b == blast);
    last_row      = ((y + 1'b1) == ye);
    row_off       = ys * row_stride;
    item_in_range = FILL_AW'(item_addr) < FILL_AW'(MEM_BYTES);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = MEM_AW'(fill_addr);
    mem_wdata = fill_set ? (mem_rdata | mask) : (mem_rdata & ~mask);
    case (state)
      S_RMW_WR: mem_we = 1'b1;
      S_WRITE: begin
        mem_we    = item_in_range;
        mem_addr  = MEM_AW'(item_addr);
        mem_wdata = item_data;
      end
      S_RD_REQ: mem_addr = MEM_AW'(item_addr);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      issue_cnt <= 3'd0;
      rsp_cnt   <= 2'd0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            fill_set  <= (in_data.opcode == OP_SET);
            item_addr <= in_data.byte_address;
            item_data <= in_data.byte_data;
            corner[0] <= xa;
            corner[1] <= xb;
            corner[2] <= ya;
            corner[3] <= yb;
            rd_value  <= 8'd0;
            issue_cnt <= 3'd0;
            rsp_cnt   <= 2'd0;
            case (in_data.opcode)
              OP_CLEAR, OP_SET: state <= S_CONV;
              OP_WRITE:         state <= S_WRITE;
              OP_READ:          state <= S_RD_REQ;
              default:          state <= S_FINISH;
            endcase
          end
        end
        S_CONV: begin
          if (!issue_cnt[2]) issue_cnt <= issue_cnt + 1'b1;
          if (crsp.valid) begin
            pix_q[rsp_cnt] <= crsp.pix;
            rsp_cnt        <= rsp_cnt + 1'b1;
            if (rsp_cnt == 2'd3) state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          xs    <= XW'(xs_c);
          xe    <= XW'(xe_c);
          ys    <= YW'(ys_c);
          ye    <= YW'(ye_c);
          empty <= (xs_c >= xe_c) || (ys_c >= ye_c);
          state <= S_ROW0;
        end
        S_ROW0: begin
          row_addr <= FILL_AW'(image_base) + FILL_AW'(row_off);
          y        <= ys;
          b        <= bfirst;
          state    <= empty ? S_FINISH : S_RMW_RD;
        end
        S_RMW_RD, S_RMW_WR: begin
          if (state == S_RMW_RD && fill_in_range) begin
            state <= S_RMW_WR;
          end else if (!last_byte) begin
            b     <= b + 1'b1;
            state <= S_RMW_RD;
          end else if (last_row) begin
            state <= S_FINISH;
          end else begin
            y        <= y + 1'b1;
            row_addr <= row_addr + FILL_AW'(row_stride);
            b        <= bfirst;
            state    <= S_RMW_RD;
          end
        end
        S_WRITE:  state <= S_FINISH;
        S_RD_REQ: state <= S_RD_DAT;
        S_RD_DAT: begin
          if (item_in_range) rd_value <= mem_rdata;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            out_data.read_data <= rd_value;
            out_data.done_res  <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
